// ===== design/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants for the first-match rule table
// request and response beats, rule record, command and status codes
// ----------------------------------------------------------------------------
`default_nettype none
package frt_pkg;

   localparam int RULE_DEPTH = 64;
   localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int CNT_W = $clog2(RULE_DEPTH + 1);

   localparam logic [7:0] PROTO_ICMP  = 8'd1;
   localparam logic [7:0] PROTO_TCP   = 8'd6;
   localparam logic [7:0] PROTO_UDP   = 8'd17;
   localparam logic [7:0] PROTO_ANY   = 8'd143;
   localparam logic [7:0] PROTO_OTHER = 8'd255;
   localparam logic [1:0] DIR_ANY     = 2'd2;
   localparam logic [15:0] PORT_ABOVE = 16'd1023;

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_ADD      = 2'd1,
      CMD_CLASSIFY = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DIRECTION = 3'd2,
      ST_PREFIX    = 3'd3,
      ST_PROTOCOL  = 3'd4,
      ST_ACK       = 3'd5,
      ST_ACTION    = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  direction;
      logic [31:0] src_ip;
      logic [7:0]  src_prefix;
      logic [31:0] dst_ip;
      logic [7:0]  dst_prefix;
      logic [7:0]  protocol;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  ack_value;
      logic [7:0]  rule_action;
   } req_type;

   typedef struct packed {
      logic        matched;
      logic [5:0]  rule_index;
      logic        verdict;
      logic [2:0]  status;
      logic [6:0]  rule_count;
   } rsp_type;

   // packet header as it travels down the cell chain
   typedef struct packed {
      logic [1:0]  direction;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [7:0]  protocol;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  ack_value;
   } pkt_type;

   // stored rule with masks already expanded
   typedef struct packed {
      logic [1:0]  direction;
      logic [31:0] src_ip;
      logic [31:0] src_mask;
      logic [31:0] dst_ip;
      logic [31:0] dst_mask;
      logic [7:0]  protocol;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [1:0]  ack_value;
      logic        action;
   } rule_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic             active;
      logic             found;
      logic [IDX_W-1:0] index;
      logic             verdict;
      pkt_type          pkt;
   } token_type;

   function automatic logic [31:0] prefix_mask(input logic [7:0] len);
      logic [31:0] m;
      begin
         if (len == 8'd0) m = 32'd0;
         else if (len >= 8'd32) m = 32'hffff_ffff;
         else m = 32'hffff_ffff << (6'd32 - len[5:0]);
         return m;
      end
   endfunction

   function automatic logic port_ok(input logic [15:0] r, input logic [15:0] p);
      return (r == 16'd0) || ((r == PORT_ABOVE) && (p > PORT_ABOVE)) || (r == p);
   endfunction

endpackage
`default_nettype wire

// ===== design/frt_cell.sv =====
// ----------------------------------------------------------------------------
// frt_cell: one rule slot of the chain
// holds a rule, compares the passing packet, forwards the search token
// ----------------------------------------------------------------------------
`default_nettype none
module frt_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire frt_pkg::rule_type             wr_rule,
   input  wire logic                          in_range,
   input  wire logic [frt_pkg::IDX_W-1:0]     my_index,
   input  wire frt_pkg::token_type            tok_in,
   output frt_pkg::token_type                 tok_out
);

   frt_pkg::rule_type  rule_ff;
   frt_pkg::token_type tok_ff, tok_next_in;
   logic hit, tcp_udp;

   always_ff @(posedge clock) begin
      if (wr_en) rule_ff <= wr_rule;
   end

   always_comb begin
      tcp_udp = (rule_ff.protocol == frt_pkg::PROTO_TCP) ||
                (rule_ff.protocol == frt_pkg::PROTO_UDP);
      hit = ((rule_ff.protocol == frt_pkg::PROTO_ANY) ||
             (rule_ff.protocol == tok_in.pkt.protocol)) &&
            ((rule_ff.direction == tok_in.pkt.direction) ||
             (rule_ff.direction == frt_pkg::DIR_ANY) ||
             (tok_in.pkt.direction == frt_pkg::DIR_ANY)) &&
            (((rule_ff.src_ip ^ tok_in.pkt.src_ip) & rule_ff.src_mask) == 32'd0) &&
            (((rule_ff.dst_ip ^ tok_in.pkt.dst_ip) & rule_ff.dst_mask) == 32'd0) &&
            (!tcp_udp ||
             (frt_pkg::port_ok(rule_ff.sport, tok_in.pkt.sport) &&
              frt_pkg::port_ok(rule_ff.dport, tok_in.pkt.dport) &&
              ((rule_ff.protocol != frt_pkg::PROTO_TCP) ||
               ((rule_ff.ack_value & tok_in.pkt.ack_value) != 2'd0))));
      tok_next_in = tok_in;
      if (tok_in.active && !tok_in.found && in_range && hit) begin
         tok_next_in.found   = 1'b1;
         tok_next_in.index   = my_index;
         tok_next_in.verdict = rule_ff.action;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) tok_ff.active <= 1'b0;
      else       tok_ff.active <= tok_next_in.active;
      tok_ff.found   <= tok_next_in.found;
      tok_ff.index   <= tok_next_in.index;
      tok_ff.verdict <= tok_next_in.verdict;
      tok_ff.pkt     <= tok_next_in.pkt;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// ===== design/firewall_rule_table_first_match.sv =====
// ----------------------------------------------------------------------------
// firewall_rule_table_first_match: first-match five-tuple rule table
// ----------------------------------------------------------------------------
// clear and add answer in the cycle after the request beat; classify answers
// once the packet has walked one rule cell per cycle through the chain and the response register.
// busy stays high from a classify beat until its response; one item at a time.
// the response strobe lasts one cycle, the receiver cannot stall.
// synchronous reset empties the table and drops any search; no clearing pass.
`default_nettype none
module firewall_rule_table_first_match (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire frt_pkg::req_type req_data,
   output logic                  rsp_valid,
   output frt_pkg::rsp_type      rsp_data
);

   localparam int D = frt_pkg::RULE_DEPTH;

   logic [frt_pkg::CNT_W-1:0] count_ff, count_in;
   logic                      busy_ff, busy_in;
   logic                      rsp_valid_ff;
   frt_pkg::rsp_type          rsp_ff, rsp_in;
   frt_pkg::rule_type         new_rule;
   frt_pkg::token_type        tok [0:D];
   frt_pkg::token_type        tok_head;
   logic [D-1:0]              wr_en;
   logic                      accept, do_add;
   logic [2:0]                add_status;

   assign accept = start && !busy_ff;

   always_comb begin
      if (count_ff >= frt_pkg::CNT_W'(D)) add_status = frt_pkg::ST_FULL;
      else if (req_data.direction > frt_pkg::DIR_ANY) add_status = frt_pkg::ST_DIRECTION;
      else if (req_data.src_prefix > 8'd32 || req_data.dst_prefix > 8'd32)
         add_status = frt_pkg::ST_PREFIX;
      else if (!(req_data.protocol == frt_pkg::PROTO_ICMP ||
                 req_data.protocol == frt_pkg::PROTO_TCP ||
                 req_data.protocol == frt_pkg::PROTO_UDP ||
                 req_data.protocol == frt_pkg::PROTO_OTHER ||
                 req_data.protocol == frt_pkg::PROTO_ANY))
         add_status = frt_pkg::ST_PROTOCOL;
      else if (req_data.ack_value == 2'd0) add_status = frt_pkg::ST_ACK;
      else if (req_data.rule_action > 8'd1) add_status = frt_pkg::ST_ACTION;
      else add_status = frt_pkg::ST_OK;
   end

   assign do_add = accept && (req_data.cmd == frt_pkg::CMD_ADD) &&
                   (add_status == frt_pkg::ST_OK);

   always_comb begin
      new_rule.direction = req_data.direction;
      new_rule.src_ip    = req_data.src_ip;
      new_rule.src_mask  = frt_pkg::prefix_mask(req_data.src_prefix);
      new_rule.dst_ip    = req_data.dst_ip;
      new_rule.dst_mask  = frt_pkg::prefix_mask(req_data.dst_prefix);
      new_rule.protocol  = req_data.protocol;
      new_rule.sport     = req_data.sport;
      new_rule.dport     = req_data.dport;
      new_rule.ack_value = req_data.ack_value;
      new_rule.action    = req_data.rule_action[0];
   end

   always_comb begin
      tok_head.active        = accept && (req_data.cmd == frt_pkg::CMD_CLASSIFY);
      tok_head.found         = 1'b0;
      tok_head.index         = '0;
      tok_head.verdict       = 1'b0;
      tok_head.pkt.direction = req_data.direction;
      tok_head.pkt.src_ip    = req_data.src_ip;
      tok_head.pkt.dst_ip    = req_data.dst_ip;
      tok_head.pkt.protocol  = req_data.protocol;
      tok_head.pkt.sport     = req_data.sport;
      tok_head.pkt.dport     = req_data.dport;
      tok_head.pkt.ack_value = req_data.ack_value;
   end

   assign tok[0] = tok_head;

   for (genvar i = 0; i < D; i++) begin : g_cell
      assign wr_en[i] = do_add && (count_ff[frt_pkg::IDX_W-1:0] ==
                                   frt_pkg::IDX_W'(i));
      frt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (wr_en[i]),
         .wr_rule  (new_rule),
         .in_range (count_ff > frt_pkg::CNT_W'(i)),
         .my_index (frt_pkg::IDX_W'(i)),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1])
      );
   end

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      rsp_in   = '0;
      rsp_in.rule_count = 7'(count_ff);
      if (accept) begin
         unique case (req_data.cmd)
            frt_pkg::CMD_CLEAR: begin
               count_in = '0;
               rsp_in.rule_count = '0;
            end
            frt_pkg::CMD_ADD: begin
               rsp_in.status = add_status;
               if (add_status == frt_pkg::ST_OK) begin
                  count_in = count_ff + 1'b1;
                  rsp_in.rule_count = 7'(count_ff + 1'b1);
               end
            end
            frt_pkg::CMD_CLASSIFY: busy_in = 1'b1;
            default: ;
         endcase
      end
      if (tok[D].active) begin
         busy_in           = 1'b0;
         rsp_in.matched    = tok[D].found;
         rsp_in.rule_index = 6'(tok[D].index);
         rsp_in.verdict    = tok[D].verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= (accept && req_data.cmd != frt_pkg::CMD_CLASSIFY) ||
                         tok[D].active;
      end
      rsp_ff <= rsp_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== design/frt_checker.sv =====
// ----------------------------------------------------------------------------
// frt_checker: port-level checks on the rule table
// handshake and response-field rules seen at the top-level ports
// ----------------------------------------------------------------------------
`default_nettype none
module frt_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire frt_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire frt_pkg::rsp_type rsp_data
);

   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd == frt_pkg::CMD_CLEAR |=>
         rsp_valid && rsp_data.rule_count == 7'd0 && rsp_data.status == frt_pkg::ST_OK)
      else $error("clear did not answer with an empty table");

   a_classify_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.cmd == frt_pkg::CMD_CLASSIFY |=> busy)
      else $error("classify did not raise busy");

   a_no_match_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.matched |-> rsp_data.rule_index == 6'd0 &&
         !rsp_data.verdict)
      else $error("unmatched response carries index or verdict");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.rule_count <= 7'(frt_pkg::RULE_DEPTH))
      else $error("rule count beyond depth");

   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_data.status == frt_pkg::ST_OK)
      else $error("busy dropped without classify response");

endmodule

bind firewall_rule_table_first_match frt_checker u_frt_checker (.*);
`default_nettype wire

// ===== tb/sv/firewall_rule_table_first_match_test.sv =====
// ----------------------------------------------------------------------------
// firewall_rule_table_first_match_test: self-checking bench for the rule table
// drives clear, add, classify and unused-command beats through the start/busy handshake,
// predicts each response from a local copy of the table and checks every field
// ----------------------------------------------------------------------------
`default_nettype none
module firewall_rule_table_first_match_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int DEPTH = frt_pkg::RULE_DEPTH;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   frt_pkg::req_type req_data;
   logic             rsp_valid;
   frt_pkg::rsp_type rsp_data;

   firewall_rule_table_first_match dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // local copy of the rule table
   frt_pkg::req_type table_rules[DEPTH];
   int               table_count;
   frt_pkg::rsp_type pending_rsp[$];
   int               error_count, idle_cycles, idle_pct;
   int               n_hits, n_misses, n_rejects, n_adds;

   function automatic logic [31:0] mask_of(logic [7:0] len);
      if (len == 0) return 32'd0;
      if (len >= 32) return 32'hffff_ffff;
      return 32'hffff_ffff << (32 - len);
   endfunction

   function automatic logic port_hit(logic [15:0] r, logic [15:0] p);
      return r == 0 || (r == frt_pkg::PORT_ABOVE && p > frt_pkg::PORT_ABOVE) || r == p;
   endfunction

   function automatic logic rule_hit(frt_pkg::req_type r, frt_pkg::req_type p);
      logic [31:0] sm, dm;
      sm = mask_of(r.src_prefix);
      dm = mask_of(r.dst_prefix);
      if (!(r.protocol == frt_pkg::PROTO_ANY || r.protocol == p.protocol)) return 1'b0;
      if (!(r.direction == p.direction || r.direction == frt_pkg::DIR_ANY ||
            p.direction == frt_pkg::DIR_ANY))
         return 1'b0;
      if ((r.src_ip & sm) != (p.src_ip & sm)) return 1'b0;
      if ((r.dst_ip & dm) != (p.dst_ip & dm)) return 1'b0;
      if (r.protocol == frt_pkg::PROTO_TCP || r.protocol == frt_pkg::PROTO_UDP) begin
         if (!port_hit(r.sport, p.sport) || !port_hit(r.dport, p.dport))
            return 1'b0;
         if (r.protocol == frt_pkg::PROTO_TCP && (r.ack_value & p.ack_value) == 0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic frt_pkg::rsp_type classify_and_update(frt_pkg::req_type q);
      frt_pkg::rsp_type r;
      r = '0;
      case (q.cmd)
         frt_pkg::CMD_CLEAR: table_count = 0;
         frt_pkg::CMD_ADD: begin
            if (table_count >= DEPTH) r.status = frt_pkg::ST_FULL;
            else if (q.direction > frt_pkg::DIR_ANY) r.status = frt_pkg::ST_DIRECTION;
            else if (q.src_prefix > 32 || q.dst_prefix > 32) r.status = frt_pkg::ST_PREFIX;
            else if (!(q.protocol inside {frt_pkg::PROTO_ICMP, frt_pkg::PROTO_TCP,
                                          frt_pkg::PROTO_UDP, frt_pkg::PROTO_OTHER,
                                          frt_pkg::PROTO_ANY}))
               r.status = frt_pkg::ST_PROTOCOL;
            else if (q.ack_value == 0) r.status = frt_pkg::ST_ACK;
            else if (q.rule_action > 1) r.status = frt_pkg::ST_ACTION;
            else begin
               table_rules[table_count] = q;
               table_count++;
               n_adds++;
            end
            if (r.status != frt_pkg::ST_OK) n_rejects++;
         end
         frt_pkg::CMD_CLASSIFY: begin
            for (int i = 0; i < table_count; i++) begin
               if (rule_hit(table_rules[i], q)) begin
                  r.matched = 1'b1;
                  r.rule_index = i[5:0];
                  r.verdict = table_rules[i].rule_action[0];
                  break;
               end
            end
            if (r.matched) n_hits++;
            else n_misses++;
         end
         default: ;
      endcase
      r.rule_count = table_count[6:0];
      return r;
   endfunction

   // one request beat; start stays high when no gap follows
   task automatic send_item(frt_pkg::req_type q);
      req_data <= q;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(classify_and_update(q));
      // each idle cycle drawn on its own
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               error_count++;
            end else begin
               frt_pkg::rsp_type e;
               e = pending_rsp.pop_front();
               if (e.matched !== rsp_data.matched || e.rule_index !== rsp_data.rule_index ||
                   e.verdict !== rsp_data.verdict || e.status !== rsp_data.status ||
                   e.rule_count !== rsp_data.rule_count) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  error_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("firewall_rule_table_first_match_test: done, errors");
            $finish;
         end
      end
   end

   function automatic frt_pkg::req_type make_rule(bit clean);
      frt_pkg::req_type q;
      logic [7:0] protos[5] = '{frt_pkg::PROTO_ICMP, frt_pkg::PROTO_TCP, frt_pkg::PROTO_UDP,
                                frt_pkg::PROTO_OTHER, frt_pkg::PROTO_ANY};
      q = {6'($urandom), $urandom, $urandom, $urandom, $urandom};
      q.cmd = frt_pkg::CMD_ADD;
      q.direction = 2'($urandom_range(2));
      q.src_prefix = 8'($urandom_range(32));
      q.dst_prefix = 8'($urandom_range(32));
      q.protocol = protos[$urandom_range(4)];
      case ($urandom_range(3))
         0: q.sport = 16'd0;
         1: q.sport = frt_pkg::PORT_ABOVE;
         2: q.sport = 16'($urandom_range(2000));
         default: ;
      endcase
      case ($urandom_range(3))
         0: q.dport = 16'd0;
         1: q.dport = frt_pkg::PORT_ABOVE;
         2: q.dport = 16'($urandom_range(2000));
         default: ;
      endcase
      q.ack_value = 2'($urandom_range(1, 3));
      q.rule_action = 8'($urandom_range(1));
      if (!clean) begin
         // break one field at random
         case ($urandom_range(5))
            0: q.direction = 2'd3;
            1: q.src_prefix = 8'($urandom_range(33, 255));
            2: q.dst_prefix = 8'($urandom_range(33, 255));
            3: q.protocol = 8'($urandom);
            4: q.ack_value = 2'd0;
            default: q.rule_action = 8'($urandom_range(2, 255));
         endcase
      end
      return q;
   endfunction

   // packet mostly aimed at a stored rule when the table holds any, perturbed now and then
   function automatic frt_pkg::req_type make_packet();
      frt_pkg::req_type q;
      q = {6'($urandom), $urandom, $urandom, $urandom, $urandom};
      q.cmd = frt_pkg::CMD_CLASSIFY;
      if (table_count > 0 && $urandom_range(3) != 0) begin
         frt_pkg::req_type r;
         logic [31:0] sm, dm;
         r = table_rules[$urandom_range(table_count - 1)];
         sm = mask_of(r.src_prefix);
         dm = mask_of(r.dst_prefix);
         q.src_ip = (r.src_ip & sm) | (q.src_ip & ~sm);
         q.dst_ip = (r.dst_ip & dm) | (q.dst_ip & ~dm);
         q.direction = ($urandom_range(3) == 0) ? 2'($urandom_range(3)) : r.direction;
         q.protocol = (r.protocol == frt_pkg::PROTO_ANY) ? 8'($urandom_range(20)) :
                      r.protocol;
         q.sport = (r.sport == frt_pkg::PORT_ABOVE) ? 16'($urandom_range(1020, 1030)) :
                   (r.sport == 16'd0) ? q.sport : r.sport;
         q.dport = (r.dport == frt_pkg::PORT_ABOVE) ? 16'($urandom_range(1020, 1030)) :
                   (r.dport == 16'd0) ? q.dport : r.dport;
         if ($urandom_range(4) == 0) q.src_ip[$urandom_range(31)] ^= 1'b1;
      end
      return q;
   endfunction

   task automatic test_add_checks();
      frt_pkg::req_type q;
      send_item('0);
      q = make_rule(1);
      q.src_prefix = 32; q.dst_prefix = 0;
      send_item(q);
      q.src_prefix = 0; q.dst_prefix = 32; q.protocol = frt_pkg::PROTO_TCP;
      send_item(q);
      for (int k = 0; k < 6; k++) begin
         q = make_rule(1);
         case (k)
            0: q.direction = 2'd3;
            1: q.src_prefix = 8'd33;
            2: q.dst_prefix = 8'd255;
            3: q.protocol = 8'd2;
            4: q.ack_value = 2'd0;
            default: q.rule_action = 8'd255;
         endcase
         send_item(q);
      end
      // first failing check wins
      q.direction = 2'd3; q.src_prefix = 8'd40;
      send_item(q);
      q = '1; q.cmd = frt_pkg::CMD_NONE;
      send_item(q);
   endtask

   task automatic test_match_rules();
      frt_pkg::req_type r, p;
      send_item('0);
      r = '0; r.cmd = frt_pkg::CMD_ADD; r.direction = 2'd0; r.protocol = frt_pkg::PROTO_TCP;
      r.sport = frt_pkg::PORT_ABOVE; r.dport = 16'd80; r.ack_value = 2'd2;
      r.rule_action = 8'd1; r.src_ip = 32'hc0a8_0100; r.src_prefix = 8'd24;
      send_item(r);
      r.protocol = frt_pkg::PROTO_ANY; r.direction = frt_pkg::DIR_ANY; r.rule_action = 8'd0;
      r.src_prefix = 0; r.ack_value = 2'd3;
      send_item(r);
      p = '0; p.cmd = frt_pkg::CMD_CLASSIFY; p.protocol = frt_pkg::PROTO_TCP;
      p.src_ip = 32'hc0a8_01ff;
      p.sport = 16'd1024; p.dport = 16'd80; p.ack_value = 2'd2;
      send_item(p);
      p.sport = 16'd1023; send_item(p);
      p.sport = 16'hffff; p.ack_value = 2'd1; send_item(p);
      p.ack_value = 2'd3; p.direction = 2'd3; send_item(p);
      p.ack_value = 2'd0; p.direction = 2'd0; send_item(p);
      p = '1; p.cmd = frt_pkg::CMD_CLASSIFY; send_item(p);
   endtask

   task automatic test_table_full();
      send_item('0);
      for (int k = 0; k < DEPTH + 2; k++) send_item(make_rule(1));
      repeat (4) send_item(make_packet());
   endtask

   task automatic test_random_mix(int items);
      int sent;
      sent = 0;
      while (sent < items) begin
         frt_pkg::req_type q;
         int r;
         r = $urandom_range(99);
         if (r < 3) begin
            q = '0; q.cmd = frt_pkg::CMD_CLEAR;
            q[$bits(frt_pkg::req_type)-3:0] = {4'($urandom), $urandom, $urandom, $urandom,
                                                $urandom};
         end else if (r < 40) q = make_rule($urandom_range(9) != 0);
         else if (r < 95) q = make_packet();
         else q = {6'($urandom), $urandom, $urandom, $urandom, $urandom};
         send_item(q);
         sent++;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      table_count = 0;
      error_count = 0;
      idle_pct = 0;
      n_hits = 0; n_misses = 0; n_rejects = 0; n_adds = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_add_checks();
      test_match_rules();
      test_table_full();
      idle_pct = 0;  test_random_mix(400);
      idle_pct = 81; test_random_mix(400);
      idle_pct = 0;  test_random_mix(300);
      idle_pct = 13; test_random_mix(400);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      $display("covered %0d rules added, %0d adds rejected", n_adds, n_rejects);
      $display("classify beats: %0d hits, %0d misses", n_hits, n_misses);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("firewall_rule_table_first_match_test: done, clean");
      else
         $display("firewall_rule_table_first_match_test: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
